### rtl/aba_pkg.sv
// Package for the ASID bitmap allocator: sizes, status codes and word layout.
// No dependencies; imported by asid_bitmap_allocator.
package aba_pkg;

   // Default number of identifiers the architecture provides
   localparam int MAX_ASIDS_DEFAULT = 256;
   // Identifiers are 8 bits wide, so at most 256 are ever tracked
   localparam int ASID_W     = 8;
   localparam int ASID_LIMIT = 256;
   localparam int COUNT_W    = 9;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   // Word widths on the stream ports
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Request kinds
   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_ALLOCATED = 3'd0,
      ST_EXHAUSTED = 3'd1,
      ST_UNTAGGED  = 3'd2,
      ST_FREED     = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

endpackage

### rtl/asid_bitmap_allocator.sv
// Top level of the ASID bitmap allocator: used-bit map, first-free search, free path.
// Depends on aba_pkg.

// Hands out address-space identifiers from a used-bit map. An allocate word returns
// the lowest unused identifier below the effective count (csr count limited to the
// map depth) and marks it used; a free word below the count clears the bit and raises
// a TLB flush. Identifier 0 is reserved and never handed out or freed. Throughput is
// one request per clock unless stalled; words pass the input and result registers.
// The result stage holds a priority encoder over the whole used map (two's-complement
// lowest-bit isolate and a one-hot encoder), which sets the cycle time. The map is in
// flip-flops and resets to entry 0 used with no clearing pass. The csr write is
// accepted every cycle and must only be issued while no request is in flight.
module asid_bitmap_allocator #(
   parameter int MAX_ASIDS = aba_pkg::MAX_ASIDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [aba_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] release_asid
   input  logic                            req_tuser,   // [0] action
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [aba_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] granted_asid,
                                                        // [8] flush_request,
                                                        // [11:9] status, [15:12] zero
   // configuration write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [aba_pkg::COUNT_W-1:0]     csr_data     // asid_count
);
   import aba_pkg::*;

   localparam int MapDepth = (MAX_ASIDS < ASID_LIMIT) ? MAX_ASIDS : ASID_LIMIT;
   localparam int IdxW     = $clog2(MapDepth);

   // registers
   logic [COUNT_W-1:0]  count_ff;
   logic [MapDepth-1:0] map_ff, map_in;
   logic                in_valid_ff;
   action_type          action_ff;
   logic [ASID_W-1:0]   rel_ff;
   logic                rsp_valid_ff;
   logic [ASID_W-1:0]   granted_ff, granted_in;
   logic                flush_ff, flush_in;
   status_type          status_ff, status_in;

   logic                process;
   logic [COUNT_W-1:0]  eff_count;
   logic [MapDepth-1:0] range_mask, free_vec, first_free;
   logic [IdxW-1:0]     first_idx;

   // handshakes: result stage advances when the output register is empty or drains
   assign process    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || process;
   assign csr_ready  = 1'b1;

   // effective count limited to the map depth
   assign eff_count = (count_ff > COUNT_W'(MapDepth)) ? COUNT_W'(MapDepth) : count_ff;

   // identifiers below the count, free ones, and the lowest free one as one-hot
   always_comb begin
      for (int i = 0; i < MapDepth; i++) begin
         range_mask[i] = COUNT_W'(i) < eff_count;
      end
   end
   assign free_vec   = ~map_ff & range_mask;
   assign first_free = free_vec & (~free_vec + MapDepth'(1));

   // one-hot to binary
   always_comb begin
      first_idx = '0;
      for (int b = 0; b < IdxW; b++) begin
         for (int i = 0; i < MapDepth; i++) begin
            if (((i >> b) & 1) == 1) begin
               first_idx[b] = first_idx[b] | first_free[i];
            end
         end
      end
   end

   // result and map update for the word in the input register
   always_comb begin
      map_in     = map_ff;
      granted_in = '0;
      flush_in   = 1'b0;
      status_in  = ST_IGNORED;
      case (action_ff)
         ACT_ALLOC: begin
            if (eff_count <= COUNT_W'(1)) begin
               status_in = ST_UNTAGGED;
            end else if (|free_vec) begin
               map_in     = map_ff | first_free;
               granted_in = ASID_W'(first_idx);
               status_in  = ST_ALLOCATED;
            end else begin
               status_in = ST_EXHAUSTED;
            end
         end
         ACT_FREE: begin
            granted_in = rel_ff;
            if (rel_ff != '0 && {1'b0, rel_ff} < eff_count) begin
               map_in[rel_ff[IdxW-1:0]] = 1'b0;
               flush_in                 = 1'b1;
               status_in                = ST_FREED;
            end
         end
         default: begin
            status_in = ST_IGNORED;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         map_ff       <= MapDepth'(1);
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (process) begin
            map_ff       <= map_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         action_ff <= action_type'(req_tuser);
         rel_ff    <= req_tdata[ASID_W-1:0];
      end
      if (process) begin
         granted_ff <= granted_in;
         flush_ff   <= flush_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, status_ff, flush_ff, granted_ff};

   // reserved identifier stays marked used
   a_zero_reserved: assert property (@(posedge clock) disable iff (reset)
      map_ff[0])
      else $error("identifier 0 lost its used bit");

   // a granted identifier is never zero and is marked used in the map
   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_ALLOCATED |-> granted_ff != '0)
      else $error("allocator granted identifier 0");

   a_grant_marked: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && status_ff == ST_ALLOCATED |-> map_ff[granted_ff[IdxW-1:0]])
      else $error("granted identifier not marked used");

   // flush only accompanies a successful free
   a_flush_freed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && flush_ff |-> status_ff == ST_FREED)
      else $error("flush raised without a free");

endmodule
